[design/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular deque unit
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int CAP_W     = 11;

    localparam int DEFAULT_MAX_DEPTH = 1024;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // operation codes
    localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;

    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

    // status of one step, from the pointer logic to the result stage
    typedef struct packed {
        logic ok;
        logic is_empty;
        logic is_full;
    } status_t;

endpackage

`default_nettype wire

[design/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// double-ended queue of signed words held in a ring memory
// ----------------------------------------------------------------------------
// an accepted word's status and ring read are registered, then loaded into the result register
// a new word is taken only after the result register has loaded the current one
// a stalled result holds the next word off until the result register frees
// reset: synchronous, active low; capacity 1024, deque empty, ring not cleared
// a capacity write empties the deque and keeps the ring contents
`default_nettype none

module circular_deque_unit #(
    parameter int MAX_DEPTH = cdq_pkg::DEFAULT_MAX_DEPTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic        [cdq_pkg::OP_W-1:0]    s_operation,
    input  wire logic signed [cdq_pkg::VALUE_W-1:0] s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_ok,
    output logic signed      [cdq_pkg::VALUE_W-1:0] m_front_value,
    output logic signed      [cdq_pkg::VALUE_W-1:0] m_rear_value,
    output logic                                    m_is_empty,
    output logic                                    m_is_full,
    input  wire logic                               cfg_wr_en,
    input  wire logic        [cdq_pkg::CAP_W-1:0]   cfg_wr_data
);

    localparam int AW = $clog2(MAX_DEPTH);
    localparam int VW = cdq_pkg::VALUE_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic             accept;
    logic             we;
    logic [AW-1:0]    waddr, raddr_a, raddr_b;
    logic [VW-1:0]    rdata_a, rdata_b;
    cdq_pkg::status_t status;

    cdq_pkg::status_t status_reg;
    logic             fwd_a_reg, fwd_b_reg;
    logic [VW-1:0]    wval_reg;

    logic             m_valid_reg, m_valid_next;
    logic             out_load;
    logic [VW-1:0]    front_val, rear_val;
    logic             ok_reg, empty_reg, full_reg;
    logic [VW-1:0]    front_reg, rear_reg;

    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;

    cdq_ptr #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ptr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .operation   (s_operation),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .we          (we),
        .waddr       (waddr),
        .raddr_a     (raddr_a),
        .raddr_b     (raddr_b),
        .status      (status)
    );

    cdq_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .we      (accept && we),
        .waddr   (waddr),
        .wdata   (s_value),
        .re      (accept),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // the inserted word may be read back in the same cycle: forward it
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
            fwd_a_reg  <= we && (waddr == raddr_a);
            fwd_b_reg  <= we && (waddr == raddr_b);
            wval_reg   <= s_value;
        end
    end

    assign out_load  = (state_reg == ST_READ) && (!m_valid_reg || m_ready);
    assign front_val = status_reg.is_empty ? cdq_pkg::EMPTY_VALUE
                     : (fwd_a_reg ? wval_reg : rdata_a);
    assign rear_val  = status_reg.is_empty ? cdq_pkg::EMPTY_VALUE
                     : (fwd_b_reg ? wval_reg : rdata_b);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            ok_reg    <= status_reg.ok;
            empty_reg <= status_reg.is_empty;
            full_reg  <= status_reg.is_full;
            front_reg <= front_val;
            rear_reg  <= rear_val;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = ok_reg;
    assign m_is_empty    = empty_reg;
    assign m_is_full     = full_reg;
    assign m_front_value = front_reg;
    assign m_rear_value  = rear_reg;

`ifndef SYNTHESIS
    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("word accepted while a step is still in flight");

    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_READ))
        else $error("result shown without a ring read");

    a_empty_values: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |->
            (m_front_value == -1 && m_rear_value == -1 && !m_is_full))
        else $error("empty deque reports stored values or full");
`endif

endmodule

`default_nettype wire

[design/cdq_ram.sv]
// ----------------------------------------------------------------------------
// cdq_ram
// generic ram, one write port and two read ports with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

[design/cdq_ptr.sv]
// ----------------------------------------------------------------------------
// cdq_ptr
// front and back slot pointers, entry count and capacity of the deque
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ptr #(
    parameter int MAX_DEPTH = cdq_pkg::DEFAULT_MAX_DEPTH,
    localparam int AW = $clog2(MAX_DEPTH),
    localparam int CW = $clog2(MAX_DEPTH + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire logic [cdq_pkg::OP_W-1:0]   operation,
    input  wire logic                       cfg_wr_en,
    input  wire logic [cdq_pkg::CAP_W-1:0]  cfg_wr_data,
    output logic                            we,
    output logic      [AW-1:0]              waddr,
    output logic      [AW-1:0]              raddr_a,
    output logic      [AW-1:0]              raddr_b,
    output cdq_pkg::status_t                status
);

    localparam int EW = (CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W;

    function automatic logic [CW-1:0] sat_cap(input logic [cdq_pkg::CAP_W-1:0] c);
        logic [EW-1:0] ce;
        ce = EW'(c);
        if (ce == '0) begin
            return CW'(1);
        end else if (ce > EW'(MAX_DEPTH)) begin
            return CW'(MAX_DEPTH);
        end
        return CW'(ce);
    endfunction

    localparam logic [CW-1:0] CAP_INIT = sat_cap(cdq_pkg::CAP_RESET);

    logic [CW-1:0] cap_reg;
    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] back_reg, back_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cfg_cap;
    logic          full_now, empty_now;
    logic          ok;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] s1;
        s1 = CW'(s) + CW'(1);
        return (s1 >= cap) ? '0 : AW'(s1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] cm1;
        cm1 = cap - CW'(1);
        return (s == '0 || CW'(s) >= cap) ? AW'(cm1) : s - AW'(1);
    endfunction

    assign cfg_cap   = sat_cap(cfg_wr_data);
    assign full_now  = count_reg >= cap_reg;
    assign empty_now = count_reg == '0;

    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        we         = 1'b0;
        waddr      = front_reg;
        ok         = 1'b0;
        case (operation)
            cdq_pkg::OP_INS_FRONT: begin
                if (!full_now) begin
                    we         = 1'b1;
                    front_next = slot_dec(front_reg, cap_reg);
                    count_next = count_reg + CW'(1);
                    ok         = 1'b1;
                end
            end
            cdq_pkg::OP_INS_BACK: begin
                if (!full_now) begin
                    we         = 1'b1;
                    waddr      = back_reg;
                    back_next  = slot_inc(back_reg, cap_reg);
                    count_next = count_reg + CW'(1);
                    ok         = 1'b1;
                end
            end
            cdq_pkg::OP_DEL_FRONT: begin
                if (!empty_now) begin
                    front_next = slot_inc(front_reg, cap_reg);
                    count_next = count_reg - CW'(1);
                    ok         = 1'b1;
                end
            end
            cdq_pkg::OP_DEL_BACK: begin
                if (!empty_now) begin
                    back_next  = slot_dec(back_reg, cap_reg);
                    count_next = count_reg - CW'(1);
                    ok         = 1'b1;
                end
            end
            default: begin
                // no operation and unused codes leave the state alone
            end
        endcase
    end

    // pointers are free slots: the entries sit one step inside them
    assign raddr_a         = slot_inc(front_next, cap_reg);
    assign raddr_b         = slot_dec(back_next, cap_reg);
    assign status.ok       = ok;
    assign status.is_empty = count_next == '0;
    assign status.is_full  = count_next >= cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_INIT;
            front_reg <= AW'(CAP_INIT - CW'(1));
            back_reg  <= '0;
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            cap_reg   <= cfg_cap;
            front_reg <= AW'(cfg_cap - CW'(1));
            back_reg  <= '0;
            count_reg <= '0;
        end else if (step) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
